FILE: hw/rtl/wc2_pkg.sv
// Shared types and constants of the 2D window convolution core.
package wc2_pkg;

    localparam int DATA_W         = 16;
    localparam int WEIGHT_W       = 16;
    localparam int FRAC_BITS      = 14;
    localparam int COL_W          = 10;
    localparam int ROW_W          = 12;
    localparam int PW_W           = 11;
    localparam int NUM_WREGS      = 7;
    localparam int WREG_W         = 64;
    localparam int APB_ADDR_W     = 6;
    localparam int APB_DATA_W     = 64;
    localparam int REG_IDX_LSB    = 3;
    localparam int HALF_WIDTH_DEF = 2;
    localparam int MAX_WIDTH_DEF  = 1024;

    localparam logic [ROW_W-1:0]  ROW_MAX      = 12'd4095;
    localparam logic [PW_W-1:0]   PW_RESET     = 11'd1024;
    localparam logic [WREG_W-1:0] WEIGHT_ONE   = 64'd16384;
    localparam int                CENTRE_WREG  = 3;

    // register map, index = paddr[5:3]
    localparam logic [2:0] REG_PADDED_WIDTH = 3'd0;
    localparam logic [2:0] REG_WEIGHTS_0    = 3'd1;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } pos_t;

endpackage

FILE: hw/rtl/wc2_if.sv
// Stream interfaces: raster samples in, filtered results out.
interface wc2_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [wc2_pkg::DATA_W-1:0]   sample;
    logic                                frame_start;

    modport source (output valid, sample, frame_start, input ready);
    modport sink   (input valid, sample, frame_start, output ready);
endinterface

interface wc2_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [wc2_pkg::DATA_W-1:0]   filtered;
    logic [wc2_pkg::COL_W-1:0]           column;
    logic [wc2_pkg::ROW_W-1:0]           row;

    modport source (output valid, filtered, column, row, input ready);
    modport sink   (input valid, filtered, column, row, output ready);
endinterface

FILE: hw/rtl/wc2_ram.sv
// Generic single-port-write, single-port-read RAM with registered read (old data on collision).
module wc2_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/wc2_mac.sv
// Weighted window sum: products, row sums, total, then round/shift/saturate.
module wc2_mac #(
    parameter int  HALF_WIDTH = wc2_pkg::HALF_WIDTH_DEF,
    localparam int WIN        = 2 * HALF_WIDTH + 1
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          en,
    input  logic                                          win_valid,
    input  logic [WIN*WIN*wc2_pkg::DATA_W-1:0]            window,
    input  logic [wc2_pkg::NUM_WREGS*wc2_pkg::WREG_W-1:0] weights,
    input  wc2_pkg::pos_t                                 win_pos,
    output logic                                          sum_valid,
    output logic signed [wc2_pkg::DATA_W-1:0]             sum_value,
    output wc2_pkg::pos_t                                 sum_pos
);

    localparam int TAPS   = WIN * WIN;
    localparam int PROD_W = wc2_pkg::DATA_W + wc2_pkg::WEIGHT_W;
    localparam int RSUM_W = PROD_W + $clog2(WIN);
    localparam int ACC_W  = RSUM_W + $clog2(WIN);
    localparam int T_W    = ACC_W + 1;
    localparam int Q_W    = T_W - wc2_pkg::FRAC_BITS;
    localparam logic signed [T_W-1:0] ROUND_BIAS = T_W'(1 << (wc2_pkg::FRAC_BITS - 1));
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (wc2_pkg::DATA_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(1 << (wc2_pkg::DATA_W - 1));

    logic signed [PROD_W-1:0] prod_next [TAPS];
    logic signed [PROD_W-1:0] prod_reg  [TAPS];
    logic signed [RSUM_W-1:0] rsum_next [WIN];
    logic signed [RSUM_W-1:0] rsum_reg  [WIN];
    logic signed [ACC_W-1:0]  total_next;
    logic signed [ACC_W-1:0]  total_reg;
    logic signed [T_W-1:0]    biased;
    logic signed [Q_W-1:0]    quot;
    logic                     prod_valid_reg;
    logic                     rsum_valid_reg;
    logic                     total_valid_reg;
    wc2_pkg::pos_t            prod_pos_reg;
    wc2_pkg::pos_t            rsum_pos_reg;
    wc2_pkg::pos_t            total_pos_reg;

    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            prod_next[k] = $signed(weights[k*wc2_pkg::WEIGHT_W +: wc2_pkg::WEIGHT_W])
                         * $signed(window[k*wc2_pkg::DATA_W +: wc2_pkg::DATA_W]);
        end
    end

    always_comb
    begin
        for (int r = 0; r < WIN; r++)
        begin
            rsum_next[r] = '0;
            for (int c = 0; c < WIN; c++)
            begin
                rsum_next[r] = rsum_next[r] + RSUM_W'(prod_reg[r*WIN+c]);
            end
        end
    end

    always_comb
    begin
        total_next = '0;
        for (int r = 0; r < WIN; r++)
        begin
            total_next = total_next + ACC_W'(rsum_reg[r]);
        end
    end

    // round half up, floor shift
    always_comb
    begin
        biased = T_W'(total_reg) + ROUND_BIAS;
        quot   = biased[T_W-1:wc2_pkg::FRAC_BITS];
        if (quot > Q_MAX)
        begin
            sum_value = wc2_pkg::DATA_W'(Q_MAX);
        end
        else if (quot < Q_MIN)
        begin
            sum_value = wc2_pkg::DATA_W'(Q_MIN);
        end
        else
        begin
            sum_value = wc2_pkg::DATA_W'(quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg  <= 1'b0;
            rsum_valid_reg  <= 1'b0;
            total_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg  <= win_valid;
            rsum_valid_reg  <= prod_valid_reg;
            total_valid_reg <= rsum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg      <= prod_next;
            rsum_reg      <= rsum_next;
            total_reg     <= total_next;
            prod_pos_reg  <= win_pos;
            rsum_pos_reg  <= prod_pos_reg;
            total_pos_reg <= rsum_pos_reg;
        end
    end

    assign sum_valid = total_valid_reg;
    assign sum_pos   = total_pos_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(total_reg) && $stable(total_valid_reg))
        else $error("sum stage moved during stall");

endmodule

FILE: hw/rtl/window_convolution_2d_core.sv
// Top level of the streaming 2D window convolution core.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+-------------------------------------
//  samples   | in  | valid/ready      | sample (s16), frame_start
//  results   | out | valid/ready      | filtered (s16), column (10), row (12)
//  APB       | in  | psel/penable     | padded_width, weights_0..6 at 8*i
//
//  One sample per cycle sustained while results are taken. A sample passes the
//  line, window, product, row sum, total and output registers; the line store
//  RAM (an entry is a column of 2*HALF_WIDTH rows) is read at accept, written
//  back by the line stage; back-to-back same-column hits use the write-back reg.
//  Reset clears counters, window and pipeline valids; the line store is not
//  cleared, no clearing pass. Output stall freezes the whole pipeline.
module window_convolution_2d_core #(
    parameter int HALF_WIDTH = wc2_pkg::HALF_WIDTH_DEF,
    parameter int MAX_WIDTH  = wc2_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    wc2_in_if.sink                            samples,
    wc2_out_if.source                         results,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wc2_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [wc2_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [wc2_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int WIN    = 2 * HALF_WIDTH + 1;
    localparam int LINES  = 2 * HALF_WIDTH;
    localparam int DW     = wc2_pkg::DATA_W;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = (CW + 1 > wc2_pkg::PW_W) ? CW + 1 : wc2_pkg::PW_W;
    localparam int LINE_W = LINES * DW;

    // ---------------- configuration registers ----------------
    logic [wc2_pkg::PW_W-1:0]   padded_width_reg;
    logic [wc2_pkg::WREG_W-1:0] weights_reg [wc2_pkg::NUM_WREGS];
    logic [2:0]                 reg_idx;
    logic [2:0]                 wreg_idx;
    logic                       cfg_write;
    logic [wc2_pkg::NUM_WREGS*wc2_pkg::WREG_W-1:0] weights_flat;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[wc2_pkg::REG_IDX_LSB +: 3];
    assign wreg_idx  = reg_idx - wc2_pkg::REG_WEIGHTS_0;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            padded_width_reg <= wc2_pkg::PW_RESET;
            for (int i = 0; i < wc2_pkg::NUM_WREGS; i++)
            begin
                weights_reg[i] <= (i == wc2_pkg::CENTRE_WREG) ? wc2_pkg::WEIGHT_ONE : '0;
            end
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                wc2_pkg::REG_PADDED_WIDTH: padded_width_reg <= pwdata[wc2_pkg::PW_W-1:0];
                default:                   weights_reg[wreg_idx] <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            wc2_pkg::REG_PADDED_WIDTH: prdata = wc2_pkg::APB_DATA_W'(padded_width_reg);
            default:                   prdata = weights_reg[wreg_idx];
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < wc2_pkg::NUM_WREGS; i++)
        begin
            weights_flat[i*wc2_pkg::WREG_W +: wc2_pkg::WREG_W] = weights_reg[i];
        end
    end

    // ---------------- pipeline control ----------------
    logic out_valid_reg;
    logic en;
    logic accept;

    // whole pipeline advances whenever the output register can take a transfer
    assign en            = !out_valid_reg || results.ready;
    assign samples.ready = en;
    assign accept        = samples.valid && samples.ready;

    // ---------------- position counters (stage 0) ----------------
    logic [CW-1:0]            column_count_reg, column_count_next;
    logic [wc2_pkg::ROW_W-1:0] row_count_reg, row_count_next;
    logic [CW-1:0]            col0;
    logic [wc2_pkg::ROW_W-1:0] row0;
    logic [WW-1:0]            pw_ext;
    logic [WW-1:0]            eff_width;
    logic                     wrap;
    logic                     emit0;
    logic [CW-1:0]            col_diff;
    wc2_pkg::pos_t            pos0;

    assign pw_ext = WW'(padded_width_reg);

    always_comb
    begin
        if (pw_ext > WW'(MAX_WIDTH))
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else if (pw_ext == '0)
        begin
            eff_width = WW'(1);
        end
        else
        begin
            eff_width = pw_ext;
        end
    end

    assign col0     = samples.frame_start ? '0 : column_count_reg;
    assign row0     = samples.frame_start ? '0 : row_count_reg;
    assign wrap     = (WW'(col0) + WW'(1)) >= eff_width;
    assign emit0    = (col0 >= CW'(LINES)) && (row0 >= wc2_pkg::ROW_W'(LINES));
    assign col_diff = col0 - CW'(LINES);
    assign pos0.column = wc2_pkg::COL_W'(col_diff);
    assign pos0.row    = row0 - wc2_pkg::ROW_W'(LINES);

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (accept)
        begin
            if (wrap)
            begin
                column_count_next = '0;
                row_count_next    = (row0 < wc2_pkg::ROW_MAX) ? row0 + 1'b1 : row0;
            end
            else
            begin
                column_count_next = col0 + 1'b1;
                row_count_next    = row0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // ---------------- line store RAM ----------------
    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic [CW-1:0]     s1_addr_reg;
    logic signed [DW-1:0] s1_sample_reg;
    wc2_pkg::pos_t     s1_pos_reg;
    logic              fwd_reg, fwd_next;
    logic [LINE_W-1:0] fwd_data_reg;
    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] line_col;
    logic [LINE_W-1:0] line_wdata;
    logic              ram_we;

    wc2_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (col0),
        .rdata (ram_rdata)
    );

    // same column read while its write-back lands: take the write-back data
    assign fwd_next   = accept && s1_valid_reg && (col0 == s1_addr_reg);
    assign line_col   = fwd_reg ? fwd_data_reg : ram_rdata;
    assign ram_we     = en && s1_valid_reg;

    // column moves up one row, new sample goes into the bottom line
    generate
        if (LINES > 1)
        begin : g_shift
            assign line_wdata = {s1_sample_reg, line_col[LINE_W-1:DW]};
        end
        else
        begin : g_single
            assign line_wdata = s1_sample_reg;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
            fwd_reg      <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_emit_reg   <= emit0;
            s1_addr_reg   <= col0;
            s1_sample_reg <= samples.sample;
            s1_pos_reg    <= pos0;
            fwd_data_reg  <= line_wdata;
        end
    end

    // ---------------- window registers ----------------
    logic signed [DW-1:0] win_reg [WIN][WIN];
    logic [WIN*WIN*DW-1:0] window_flat;
    logic                  s2_valid_reg;
    wc2_pkg::pos_t         s2_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                for (int c = 0; c < WIN; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < WIN; r++)
                begin
                    for (int c = 0; c < WIN - 1; c++)
                    begin
                        win_reg[r][c] <= win_reg[r][c+1];
                    end
                    win_reg[r][WIN-1] <= (r < LINES) ? line_col[r*DW +: DW] : s1_sample_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pos_reg <= s1_pos_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < WIN; r++)
        begin
            for (int c = 0; c < WIN; c++)
            begin
                window_flat[(r*WIN+c)*DW +: DW] = win_reg[r][c];
            end
        end
    end

    // ---------------- weighted sum ----------------
    logic                 sum_valid;
    logic signed [DW-1:0] sum_value;
    wc2_pkg::pos_t        sum_pos;

    wc2_mac #(
        .HALF_WIDTH (HALF_WIDTH)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .win_valid (s2_valid_reg),
        .window    (window_flat),
        .weights   (weights_flat),
        .win_pos   (s2_pos_reg),
        .sum_valid (sum_valid),
        .sum_value (sum_value),
        .sum_pos   (sum_pos)
    );

    // ---------------- output register ----------------
    logic signed [DW-1:0] out_filtered_reg;
    wc2_pkg::pos_t        out_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_filtered_reg <= sum_value;
            out_pos_reg      <= sum_pos;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.filtered = out_filtered_reg;
    assign results.column   = out_pos_reg.column;
    assign results.row      = out_pos_reg.row;

    // ---------------- checks ----------------
    a_window_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(window_flat))
        else $error("window shifted during stall");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && samples.frame_start && (eff_width > WW'(1))
        |=> column_count_reg == CW'(1))
        else $error("frame start did not restart column count");

    a_row_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !samples.frame_start && (row_count_reg == wc2_pkg::ROW_MAX)
        |=> row_count_reg == wc2_pkg::ROW_MAX)
        else $error("row count left saturation");

    a_fwd_needs_writer: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("forward flag without item in line stage");

    a_out_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(sum_valid))
        else $error("result without sum stage item");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the streaming 2D window convolution core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Run limits. The slowest correct run has some 1.2k samples, idle gaps on
    // both sides, one long stall and a drain after every phase.
    localparam int LIMIT_CYCLES = 40_000;
    localparam int DRAIN_CYCLES = 16;     // lets samples without a result leave the pipeline
    localparam int RANDOM_ITEMS = 880;
    localparam int LONG_HOLD    = 400;    // receiver stall that backs up the input

    typedef struct {
        logic signed [wc2_pkg::DATA_W-1:0] filtered;
        logic [wc2_pkg::COL_W-1:0]         column;
        logic [wc2_pkg::ROW_W-1:0]         row;
    } cell_t;

    // Tracks the filter state, predicts the filtered cells and checks them in order.
    class window_sum_tracker;
        localparam int WIN      = 2 * wc2_pkg::HALF_WIDTH_DEF + 1;
        localparam int LINES    = 2 * wc2_pkg::HALF_WIDTH_DEF;
        localparam int LINE_LEN = wc2_pkg::MAX_WIDTH_DEF;

        bit [wc2_pkg::PW_W-1:0]           padded_width;
        bit [wc2_pkg::WREG_W-1:0]         weight_regs[wc2_pkg::NUM_WREGS];
        bit signed [wc2_pkg::DATA_W-1:0]  line_rows[LINES][LINE_LEN];
        bit signed [wc2_pkg::DATA_W-1:0]  window[WIN*WIN];
        int unsigned                      col_count;
        int unsigned                      row_count;
        cell_t                            expected_cells[$];
        int                               errors;

        function new();
            padded_width = wc2_pkg::PW_RESET;
            weight_regs[wc2_pkg::CENTRE_WREG] = wc2_pkg::WEIGHT_ONE;
        endfunction

        function void write_register(bit [2:0] idx, bit [wc2_pkg::WREG_W-1:0] value);
            if (idx == wc2_pkg::REG_PADDED_WIDTH)
                padded_width = value[wc2_pkg::PW_W-1:0];
            else
                weight_regs[idx - wc2_pkg::REG_WEIGHTS_0] = value;
        endfunction

        function void take_sample(bit signed [wc2_pkg::DATA_W-1:0] s, bit opens);
            int unsigned                       w;
            int unsigned                       col;
            int unsigned                       row;
            longint                            acc;
            longint                            q;
            bit signed [wc2_pkg::WEIGHT_W-1:0] wt;
            cell_t                             entry;
            w = padded_width;
            if (w > LINE_LEN)
                w = LINE_LEN;
            if (w == 0)
                w = 1;
            if (opens)
            begin
                col_count = 0;
                row_count = 0;
            end
            col = (col_count >= LINE_LEN) ? LINE_LEN - 1 : col_count;
            row = row_count;
            for (int r = 0; r < WIN; r++)
            begin
                for (int c = 0; c < WIN - 1; c++)
                    window[r*WIN + c] = window[r*WIN + c + 1];
                window[r*WIN + WIN - 1] = (r < LINES) ? line_rows[r][col] : s;
            end
            for (int r = 0; r < LINES - 1; r++)
                line_rows[r][col] = line_rows[r+1][col];
            line_rows[LINES-1][col] = s;
            if (col >= LINES && row >= LINES)
            begin
                acc = 0;
                for (int k = 0; k < WIN*WIN; k++)
                begin
                    wt = weight_regs[k/4][16*(k%4) +: 16];
                    acc += longint'(wt) * longint'(window[k]);
                end
                // round half up, then floor shift
                q = (acc + (longint'(1) << (wc2_pkg::FRAC_BITS - 1))) >>> wc2_pkg::FRAC_BITS;
                if (q > 32767)
                    q = 32767;
                if (q < -32768)
                    q = -32768;
                entry.filtered = q[wc2_pkg::DATA_W-1:0];
                entry.column   = wc2_pkg::COL_W'(col - LINES);
                entry.row      = wc2_pkg::ROW_W'(row - LINES);
                expected_cells = {expected_cells, entry};
            end
            if (col + 1 >= w)
            begin
                col_count = 0;
                if (row < wc2_pkg::ROW_MAX)
                    row_count = row + 1;
            end
            else
                col_count = col + 1;
        endfunction

        function void check_result(bit signed [wc2_pkg::DATA_W-1:0] f,
                                   bit [wc2_pkg::COL_W-1:0] c,
                                   bit [wc2_pkg::ROW_W-1:0] r);
            cell_t want;
            if (expected_cells.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result filtered=%0d column=%0d row=%0d",
                         $time, f, c, r);
                return;
            end
            want = expected_cells.pop_front();
            if (want.filtered !== f || want.column !== c || want.row !== r)
            begin
                errors++;
                $display("%0t: mismatch expected filtered=%0d column=%0d row=%0d,",
                         $time, want.filtered, want.column, want.row,
                         " got filtered=%0d column=%0d row=%0d", f, c, r);
            end
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [wc2_pkg::APB_ADDR_W-1:0] paddr;
    logic [wc2_pkg::APB_DATA_W-1:0] pwdata;
    logic [wc2_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    wc2_in_if  samples_bus();
    wc2_out_if results_bus();

    window_sum_tracker sum_tracker = new();

    int cycle_count = 0;
    int pushed = 0;        // samples accepted by the block so far
    bit hold_req = 1'b0;   // asks the receiver for its one long stall
    bit hold_done = 1'b0;
    int hold_left = 0;

    window_convolution_2d_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_bus),
        .results (results_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Both sides idle at random (12 in 100 draws); one stretch in four, where
    // cycle_count[9:8] is 3, runs without any idling so the pipeline sees full rate.
    function automatic bit idle_now();
        if (cycle_count[9:8] == 2'd3)
            return 1'b0;
        return $urandom_range(99) < 12;
    endfunction

    // Input monitor: each accepted transfer feeds the predictor.
    always @(posedge clk)
    begin
        if (rst_n && samples_bus.valid && samples_bus.ready)
        begin
            sum_tracker.take_sample(samples_bus.sample, samples_bus.frame_start);
            pushed <= pushed + 1;
        end
    end

    // Output monitor: each accepted transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && results_bus.valid && results_bus.ready)
            sum_tracker.check_result(results_bus.filtered, results_bus.column,
                                     results_bus.row);
    end

    // Receiver: random back-pressure, plus one long stall on request so the
    // pipeline fills and pushes back on the sample stream.
    initial
    begin
        results_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_bus.ready <= 1'b0;
            end
            else
                results_bus.ready <= !idle_now();
        end
    end

    // APB write: setup cycle, access cycle, then back to idle.
    task automatic write_reg(input logic [2:0] idx, input logic [wc2_pkg::WREG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= wc2_pkg::APB_ADDR_W'(idx) << wc2_pkg::REG_IDX_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sum_tracker.write_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Weight word styles: 0 any bits, 1 small signed lanes, 2 extreme lanes.
    function automatic logic [wc2_pkg::WREG_W-1:0] weight_word(input int style);
        logic [wc2_pkg::WREG_W-1:0]   word;
        logic [wc2_pkg::WEIGHT_W-1:0] lane;
        for (int i = 0; i < 4; i++)
        begin
            case (style)
                0: lane = wc2_pkg::WEIGHT_W'($urandom);
                1: lane = wc2_pkg::WEIGHT_W'($urandom_range(4095)) - 16'd2048;
                default:
                    case ($urandom_range(4))
                        0: lane = 16'h8000;
                        1: lane = 16'h7FFF;
                        2: lane = 16'h0000;
                        3: lane = 16'hFFFF;
                        default: lane = 16'h4000;
                    endcase
            endcase
            word[16*i +: 16] = lane;
        end
        return word;
    endfunction

    task automatic write_weights(input int style);
        for (int k = 0; k < wc2_pkg::NUM_WREGS; k++)
            write_reg(wc2_pkg::REG_WEIGHTS_0 + 3'(k), weight_word(style));
    endtask

    // Sample styles: 0 any value, 1 extremes, 2 around the rounding point
    // of the smallest weight, 3 mostly any value with some extremes.
    function automatic logic signed [wc2_pkg::DATA_W-1:0] pick_sample(input int style);
        logic signed [wc2_pkg::DATA_W-1:0] extreme;
        logic signed [wc2_pkg::DATA_W-1:0] near_half;
        case ($urandom_range(4))
            0: extreme = 16'sh8000;
            1: extreme = 16'sh7FFF;
            2: extreme = 16'sh0000;
            3: extreme = 16'shFFFF;
            default: extreme = 16'sh0001;
        endcase
        case ($urandom_range(4))
            0: near_half = 16'sd8192;
            1: near_half = -16'sd8192;
            2: near_half = -16'sd8193;
            3: near_half = 16'sd8191;
            default: near_half = -16'sd8191;
        endcase
        case (style)
            0: return wc2_pkg::DATA_W'($urandom);
            1: return extreme;
            2: return near_half;
            default:
                return ($urandom_range(7) == 0) ? extreme : wc2_pkg::DATA_W'($urandom);
        endcase
    endfunction

    // One sample transfer, with random idle cycles ahead of it.
    task automatic push_sample(input logic signed [wc2_pkg::DATA_W-1:0] s,
                               input logic opens);
        while (idle_now())
        begin
            samples_bus.valid <= 1'b0;
            @(posedge clk);
        end
        samples_bus.valid       <= 1'b1;
        samples_bus.sample      <= s;
        samples_bus.frame_start <= opens;
        @(posedge clk);
        while (!samples_bus.ready)
            @(posedge clk);
    endtask

    // A run of n samples; the first may open a frame, later ones open one
    // with odds 1 in fs_odds (0: never).
    task automatic send_run(input int n, input bit opens, input int style, input int fs_odds);
        for (int i = 0; i < n; i++)
            push_sample(pick_sample(style),
                        (i == 0) ? opens : (fs_odds > 0 && $urandom_range(fs_odds - 1) == 0));
    endtask

    // Registers change only with the block idle: drop valid, let every expected
    // result arrive, then give samples without a result time to leave the pipe.
    task automatic settle();
        samples_bus.valid <= 1'b0;
        @(posedge clk);
        while (sum_tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int w;
        int eff;
        int kind;
        int rows;
        int phase_items;
        int phase_base;
        int random_base;
        bit first;

        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        samples_bus.valid       <= 1'b0;
        samples_bus.sample      <= '0;
        samples_bus.frame_start <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset weights, no frame start at all: counters begin at zero and
        // the unit centre weight passes the window centre straight through.
        // The receiver stalls long here, so the pipeline fills and the input
        // backs up while samples keep coming.
        write_reg(wc2_pkg::REG_PADDED_WIDTH, 64'd8);
        hold_req <= 1'b1;
        send_run(8 * 8, 1'b0, 0, 0);

        // Narrowest useful width, all weights -2.0: full-scale samples drive
        // the sum into both saturation limits.
        settle();
        write_reg(wc2_pkg::REG_PADDED_WIDTH, 64'd5);
        for (int k = 0; k < wc2_pkg::NUM_WREGS; k++)
            write_reg(wc2_pkg::REG_WEIGHTS_0 + 3'(k), 64'h8000_8000_8000_8000);
        for (int i = 0; i < 25; i++)
            push_sample(16'sh7FFF, i == 0);
        for (int i = 0; i < 25; i++)
            push_sample(16'sh8000, i == 0);

        // Smallest weight at the centre: the sum sits right at the rounding step.
        settle();
        write_reg(wc2_pkg::REG_PADDED_WIDTH, 64'd6);
        for (int k = 0; k < wc2_pkg::NUM_WREGS; k++)
            write_reg(wc2_pkg::REG_WEIGHTS_0 + 3'(k),
                      (k == wc2_pkg::CENTRE_WREG) ? 64'd1 : 64'd0);
        send_run(36, 1'b1, 2, 0);

        // Widths 0 to 4: the column never reaches the window, nothing comes out.
        for (int i = 0; i < 5; i++)
        begin
            settle();
            write_reg(wc2_pkg::REG_PADDED_WIDTH, wc2_pkg::WREG_W'(i));
            send_run(12, 1'b1, 0, 0);
        end

        // Random phases: new width and weights each time, then mostly whole
        // frames (some continuing the previous one), some cut short, some noise.
        settle();
        random_base = pushed;
        while (pushed - random_base < RANDOM_ITEMS)
        begin
            settle();
            kind = $urandom_range(99);
            if (kind < 6)
                w = $urandom_range(4);
            else if (kind < 20)
                w = $urandom_range(17, 40);
            else
                w = $urandom_range(5, 16);
            eff = (w == 0) ? 1 : w;
            write_reg(wc2_pkg::REG_PADDED_WIDTH, wc2_pkg::WREG_W'(w));
            write_weights($urandom_range(2));
            phase_items = $urandom_range(60, 140);
            phase_base  = pushed;
            first       = 1'b1;
            // the first sample after a width change always opens a frame
            while (pushed - phase_base < phase_items)
            begin
                kind = $urandom_range(99);
                rows = $urandom_range(5, 8);
                if (kind < 75)
                    send_run(rows * eff, first || $urandom_range(3) != 0, 3, 0);
                else if (kind < 88)
                    send_run($urandom_range(1, rows * eff - 1), 1'b1, 3, 0);
                else
                    send_run($urandom_range(1, 20), first || $urandom_range(1) != 0, 3, 6);
                first = 1'b0;
            end
        end

        settle();
        if (sum_tracker.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sum_tracker.pending());
        if (sum_tracker.errors == 0 && sum_tracker.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: window_convolution_2d_core.f
hw/rtl/wc2_pkg.sv
hw/rtl/wc2_if.sv
hw/rtl/wc2_ram.sv
hw/rtl/wc2_mac.sv
hw/rtl/window_convolution_2d_core.sv
tb/testbench.sv
